/* src/spsd_pkg.sv */
// shared types and constants for the steady pose settle detector
// no dependencies; used by every module of the block
`default_nettype none

package spsd_pkg;

    // field widths
    localparam int POS_W    = 24;
    localparam int ROT_W    = 16;
    localparam int TICK_W   = 16;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 2;
    localparam int NREQ_W   = 5;
    localparam int THR_W    = 52;
    localparam int TMO_W    = 32;
    localparam int SQ_W     = 2 * POS_W;
    localparam int ACC_W    = SQ_W + 2;
    localparam int CFG_IDX_W = 2;

    // stream payload widths
    localparam int S_DATA_W = TICK_W + 3 * POS_W + 4 * ROT_W;
    localparam int M_DATA_W = 3 * POS_W + 4 * ROT_W;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POLL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_RUN  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FAIL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // configuration reset values
    localparam logic [NREQ_W-1:0] RST_REQUIRED = 5'd5;
    localparam logic [THR_W-1:0]  RST_THRESH   = 52'd100;
    localparam logic [TMO_W-1:0]  RST_TIMEOUT  = 32'd10000;

    // axis selector for the shared squarer
    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_ACC,
        ST_CMP,
        ST_DONE
    } t_state;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic  sq_en;
        t_axis axis;
        logic  acc_load;
        logic  acc_add;
        logic  cmp_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* src/spsd_cell.sv */
// one window cell: holds a position, passes it on when a sample shifts in,
// and measures its squared distance to the newest sample; uses spsd_pkg
`default_nettype none

module spsd_cell (
    input  wire                          i_clk,
    input  spsd_pkg::t_cell_ctl          i_ctl,
    input  wire                          i_shift,
    input  wire  [spsd_pkg::POS_W-1:0]   i_x,
    input  wire  [spsd_pkg::POS_W-1:0]   i_y,
    input  wire  [spsd_pkg::POS_W-1:0]   i_z,
    input  wire  [spsd_pkg::POS_W-1:0]   i_ref_x,
    input  wire  [spsd_pkg::POS_W-1:0]   i_ref_y,
    input  wire  [spsd_pkg::POS_W-1:0]   i_ref_z,
    input  wire  [spsd_pkg::THR_W-1:0]   i_thr,
    output logic [spsd_pkg::POS_W-1:0]   o_x,
    output logic [spsd_pkg::POS_W-1:0]   o_y,
    output logic [spsd_pkg::POS_W-1:0]   o_z,
    output logic                         o_over
);

    logic [spsd_pkg::POS_W-1:0] r_x, r_y, r_z;
    logic [spsd_pkg::SQ_W-1:0]  r_sq;
    logic [spsd_pkg::ACC_W-1:0] r_acc;
    logic                       r_over;

    logic [spsd_pkg::POS_W-1:0] w_own, w_ref;
    logic signed [spsd_pkg::POS_W:0] w_diff;
    logic [spsd_pkg::POS_W:0]   w_abs;
    logic [spsd_pkg::SQ_W-1:0]  w_sq;

    // window position, shifted from the neighbour
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end
    end

    // pick the axis under test
    always_comb begin
        case (i_ctl.axis)
            spsd_pkg::AXIS_X: begin
                w_own = r_x;
                w_ref = i_ref_x;
            end
            spsd_pkg::AXIS_Y: begin
                w_own = r_y;
                w_ref = i_ref_y;
            end
            spsd_pkg::AXIS_Z: begin
                w_own = r_z;
                w_ref = i_ref_z;
            end
            default: begin
                w_own = r_x;
                w_ref = i_ref_x;
            end
        endcase
    end

    // magnitude of the difference, then its square
    assign w_diff = $signed({w_own[spsd_pkg::POS_W-1], w_own})
                  - $signed({w_ref[spsd_pkg::POS_W-1], w_ref});
    assign w_abs  = w_diff[spsd_pkg::POS_W] ? (~w_diff + 1'b1) : w_diff;
    assign w_sq   = w_abs[spsd_pkg::POS_W-1:0] * w_abs[spsd_pkg::POS_W-1:0];

    // square register, accumulator and threshold compare
    always_ff @(posedge i_clk) begin
        if (i_ctl.sq_en) begin
            r_sq <= w_sq;
        end
        if (i_ctl.acc_load) begin
            r_acc <= {2'b00, r_sq};
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + {2'b00, r_sq};
        end
        if (i_ctl.cmp_en) begin
            r_over <= {{(spsd_pkg::THR_W-spsd_pkg::ACC_W){1'b0}}, r_acc} > i_thr;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_over = r_over;

endmodule

`default_nettype wire

/* src/steady_pose_settle_detector.sv */
// flow: start, no-sample, timed-out and not-yet-full polls go from idle
//   straight to DONE; a sample completing the window first passes SQ0 .. CMP
// one item at a time: the next waits until the result is loaded; the per-cell
//   squarer steps over the three axes, then accumulates and compares
// reset: synchronous active low; clears sequencer, fill count, elapsed time,
//   output valid and restores the configuration defaults; window not cleared
`default_nettype none

module steady_pose_settle_detector #(
    parameter int WINDOW_DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input items
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    // elapsed_ticks, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w
    input  wire  [spsd_pkg::S_DATA_W-1:0]     i_s_tdata,
    // req_type
    input  wire  [spsd_pkg::REQ_W-1:0]        i_s_tuser,
    // result items
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // out_x, out_y, out_z, out_rot_x, out_rot_y, out_rot_z, out_rot_w
    output logic [spsd_pkg::M_DATA_W-1:0]     o_m_tdata,
    // status
    output logic [spsd_pkg::STAT_W-1:0]       o_m_tuser,
    // configuration writes
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [spsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [spsd_pkg::THR_W-1:0]        i_cfg_data
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int XW = (CW > spsd_pkg::NREQ_W) ? CW : spsd_pkg::NREQ_W;
    localparam int PW = spsd_pkg::POS_W;
    localparam int RW = spsd_pkg::ROT_W;
    localparam int TW = spsd_pkg::TICK_W;

    // configuration
    logic [spsd_pkg::NREQ_W-1:0] r_cfg_req;
    logic [spsd_pkg::THR_W-1:0]  r_cfg_thr;
    logic [spsd_pkg::TMO_W-1:0]  r_cfg_tmo;

    // run state
    spsd_pkg::t_state r_state, n_state;
    logic [CW-1:0]                r_fill;
    logic [spsd_pkg::TMO_W-1:0]   r_elapsed;
    logic [CW-1:0]                r_need;
    logic                         r_chk;
    logic [spsd_pkg::STAT_W-1:0]  r_status;
    logic [4*RW-1:0]              r_rot;

    // output register
    logic                         r_m_valid;
    logic [spsd_pkg::M_DATA_W-1:0] r_m_data;
    logic [spsd_pkg::STAT_W-1:0]  r_m_user;

    // sequencer outputs
    spsd_pkg::t_cell_ctl w_ctl;
    logic                w_out_load;

    // input decode
    logic                        w_accept;
    logic [spsd_pkg::REQ_W-1:0]  w_req;
    logic [spsd_pkg::TMO_W:0]    w_sum;
    logic [spsd_pkg::TMO_W-1:0]  w_elapsed;
    logic                        w_timeout;
    logic [XW-1:0]               w_req_ext;
    logic [CW-1:0]               w_need;
    logic [CW:0]                 w_fill_inc;
    logic [CW-1:0]               w_fill_new;
    logic                        w_sample;
    logic                        w_chk;

    // cell chain
    logic [PW-1:0] w_cx [WINDOW_DEPTH+1];
    logic [PW-1:0] w_cy [WINDOW_DEPTH+1];
    logic [PW-1:0] w_cz [WINDOW_DEPTH+1];
    logic [WINDOW_DEPTH-1:0] w_over;
    logic [WINDOW_DEPTH-1:0] w_fail_bits;
    logic                    w_fail;
    logic [spsd_pkg::STAT_W-1:0] w_status;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_req    = i_s_tuser;

    // saturating elapsed time and timeout test
    assign w_sum     = {1'b0, r_elapsed} + (spsd_pkg::TMO_W + 1)'(i_s_tdata[TW-1:0]);
    assign w_elapsed = w_sum[spsd_pkg::TMO_W] ? '1 : w_sum[spsd_pkg::TMO_W-1:0];
    assign w_timeout = w_elapsed > r_cfg_tmo;

    // required count clamped to one .. window depth
    assign w_req_ext = XW'(r_cfg_req);
    always_comb begin
        if (w_req_ext == '0) begin
            w_need = CW'(1);
        end else if (w_req_ext > XW'(WINDOW_DEPTH)) begin
            w_need = CW'(WINDOW_DEPTH);
        end else begin
            w_need = CW'(w_req_ext);
        end
    end

    assign w_fill_inc = {1'b0, r_fill} + 1'b1;
    assign w_fill_new = (w_fill_inc > {1'b0, w_need}) ? w_need : w_fill_inc[CW-1:0];
    assign w_sample   = (w_req == spsd_pkg::REQ_SAMPLE) && !w_timeout;
    assign w_chk      = w_sample && (w_fill_new == w_need);

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_req <= spsd_pkg::RST_REQUIRED;
            r_cfg_thr <= spsd_pkg::RST_THRESH;
            r_cfg_tmo <= spsd_pkg::RST_TIMEOUT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spsd_pkg::CFG_REQUIRED: r_cfg_req <= i_cfg_data[spsd_pkg::NREQ_W-1:0];
                spsd_pkg::CFG_THRESH:   r_cfg_thr <= i_cfg_data;
                spsd_pkg::CFG_TIMEOUT:  r_cfg_tmo <= i_cfg_data[spsd_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // run state updated when an item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_elapsed <= '0;
            r_chk     <= 1'b0;
            r_status  <= spsd_pkg::STAT_RUN;
        end else if (w_accept) begin
            r_chk <= 1'b0;
            if (w_req == spsd_pkg::REQ_START) begin
                r_fill    <= '0;
                r_elapsed <= '0;
                r_status  <= spsd_pkg::STAT_RUN;
            end else begin
                r_elapsed <= w_elapsed;
                r_status  <= w_timeout ? spsd_pkg::STAT_FAIL : spsd_pkg::STAT_RUN;
                if (w_sample) begin
                    r_fill <= w_fill_new;
                    r_chk  <= w_chk;
                end
            end
        end
    end

    // item payload kept for the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_need <= w_need;
            r_rot  <= i_s_tdata[spsd_pkg::S_DATA_W-1 -: 4*RW];
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spsd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spsd_pkg::ST_IDLE: if (w_accept) begin
                n_state = (w_req != spsd_pkg::REQ_START && w_chk)
                        ? spsd_pkg::ST_SQ0 : spsd_pkg::ST_DONE;
            end
            spsd_pkg::ST_SQ0: n_state = spsd_pkg::ST_SQ1;
            spsd_pkg::ST_SQ1: n_state = spsd_pkg::ST_SQ2;
            spsd_pkg::ST_SQ2: n_state = spsd_pkg::ST_ACC;
            spsd_pkg::ST_ACC: n_state = spsd_pkg::ST_CMP;
            spsd_pkg::ST_CMP: n_state = spsd_pkg::ST_DONE;
            spsd_pkg::ST_DONE: if (w_out_load) begin
                n_state = spsd_pkg::ST_IDLE;
            end
            default: n_state = spsd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready     = 1'b0;
        w_out_load     = 1'b0;
        w_ctl.sq_en    = 1'b0;
        w_ctl.axis     = spsd_pkg::AXIS_X;
        w_ctl.acc_load = 1'b0;
        w_ctl.acc_add  = 1'b0;
        w_ctl.cmp_en   = 1'b0;
        case (r_state)
            spsd_pkg::ST_IDLE: o_s_tready = 1'b1;
            spsd_pkg::ST_SQ0: begin
                w_ctl.sq_en = 1'b1;
                w_ctl.axis  = spsd_pkg::AXIS_X;
            end
            spsd_pkg::ST_SQ1: begin
                w_ctl.sq_en    = 1'b1;
                w_ctl.axis     = spsd_pkg::AXIS_Y;
                w_ctl.acc_load = 1'b1;
            end
            spsd_pkg::ST_SQ2: begin
                w_ctl.sq_en   = 1'b1;
                w_ctl.axis    = spsd_pkg::AXIS_Z;
                w_ctl.acc_add = 1'b1;
            end
            spsd_pkg::ST_ACC: w_ctl.acc_add = 1'b1;
            spsd_pkg::ST_CMP: w_ctl.cmp_en  = 1'b1;
            spsd_pkg::ST_DONE: w_out_load = !r_m_valid || i_m_tready;
            default: ;
        endcase
    end

    // chain of window cells, new sample enters at cell 0
    assign w_cx[0] = i_s_tdata[TW +: PW];
    assign w_cy[0] = i_s_tdata[TW+PW +: PW];
    assign w_cz[0] = i_s_tdata[TW+2*PW +: PW];

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        spsd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_shift (w_accept && w_sample),
            .i_x     (w_cx[g]),
            .i_y     (w_cy[g]),
            .i_z     (w_cz[g]),
            .i_ref_x (w_cx[1]),
            .i_ref_y (w_cy[1]),
            .i_ref_z (w_cz[1]),
            .i_thr   (r_cfg_thr),
            .o_x     (w_cx[g+1]),
            .o_y     (w_cy[g+1]),
            .o_z     (w_cz[g+1]),
            .o_over  (w_over[g])
        );
        // only the newest required entries count
        assign w_fail_bits[g] = w_over[g] && (CW'(g) < r_need);
    end

    assign w_fail   = |w_fail_bits;
    assign w_status = r_chk ? (w_fail ? spsd_pkg::STAT_RUN : spsd_pkg::STAT_OK) : r_status;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_user <= w_status;
            if (w_status == spsd_pkg::STAT_OK) begin
                r_m_data <= {r_rot, w_cz[1], w_cy[1], w_cx[1]};
            end else begin
                r_m_data <= '0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

`default_nettype wire

/* src/spsd_checker.sv */
// port-level checks for the steady pose settle detector, bound to the top level
// depends on spsd_pkg and on the ports of steady_pose_settle_detector
`default_nettype none

module spsd_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_s_tvalid,
    input wire                               o_s_tready,
    input wire                               o_m_tvalid,
    input wire                               i_m_tready,
    input wire [spsd_pkg::M_DATA_W-1:0]      o_m_tdata,
    input wire [spsd_pkg::STAT_W-1:0]        o_m_tuser
);

    // a stalled result item holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result item changed");

    // only a success carries a pose
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != spsd_pkg::STAT_OK) |-> (o_m_tdata == '0))
        else $error("non-success result carries data");

    // one item in flight: no accept right after an accept
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item accepted while another is in work");

    // a fresh result appears only while input is held off
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared without an item in work");

endmodule

bind steady_pose_settle_detector spsd_checker u_spsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

/* tb/sv/tb_steady_pose_settle_detector.sv */
`timescale 1ns / 100ps

// self-checking testbench for the steady pose settle detector: directed and
// random pose streams, each result compared with a behavioural predictor
// depends on spsd_pkg and steady_pose_settle_detector

module tb_steady_pose_settle_detector;
    import spsd_pkg::*;

    localparam int DEPTH = 16;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS = 100;

    // request code with no meaning of its own, behaves as a plain poll
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;
    localparam logic signed [ROT_W-1:0] ROT_MAX = 16'sh7FFF;
    localparam logic signed [ROT_W-1:0] ROT_MIN = 16'sh8000;

    typedef struct packed {
        logic [REQ_W-1:0]         req;
        logic [TICK_W-1:0]        ticks;
        logic signed [POS_W-1:0]  x, y, z;
        logic signed [ROT_W-1:0]  rx, ry, rz, rw;
    } pose_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [POS_W-1:0]  x, y, z;
        logic signed [ROT_W-1:0]  rx, ry, rz, rw;
    } verdict_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata;
    logic [REQ_W-1:0]      i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic [STAT_W-1:0]     o_m_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [THR_W-1:0]      i_cfg_data;

    // predictor copy of the registers and the window
    logic [NREQ_W-1:0]        cfg_required;
    logic [THR_W-1:0]         cfg_thresh;
    logic [TMO_W-1:0]         cfg_timeout;
    logic signed [POS_W-1:0]  win_x [DEPTH];
    logic signed [POS_W-1:0]  win_y [DEPTH];
    logic signed [POS_W-1:0]  win_z [DEPTH];
    int unsigned              win_fill;
    logic [TMO_W-1:0]         elapsed_sum;

    verdict_t pending_verdicts [$];

    int n_items;
    int n_verdicts;
    int n_settled;
    int n_timed_out;
    int n_errors;
    int n_settings;
    int send_idle_pct = 6;
    int recv_idle_pct = 71;
    bit hold_pending;

    steady_pose_settle_detector #(
        .WINDOW_DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("steady_pose_settle_detector: mismatch");
        $finish;
    end

    // squared difference along one axis, exact in 64 bits
    function automatic longint unsigned axis_sq(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
        longint d;
        d = a - b;
        return d * d;
    endfunction

    // expected result of one item, updates the predictor state
    function automatic verdict_t predict_settle(input pose_req_t it);
        verdict_t          v;
        int unsigned       need;
        logic [TMO_W:0]    sum;
        bit                agree;
        v = '0;
        v.status = STAT_RUN;
        if (it.req == REQ_START) begin
            win_fill = 0;
            elapsed_sum = '0;
            return v;
        end
        // elapsed time saturates at the counter's top
        sum = {1'b0, elapsed_sum} + it.ticks;
        elapsed_sum = sum[TMO_W] ? '1 : sum[TMO_W-1:0];
        if (elapsed_sum > cfg_timeout) begin
            v.status = STAT_FAIL;
            return v;
        end
        if (it.req != REQ_SAMPLE)
            return v;
        need = cfg_required;
        if (need == 0)
            need = 1;
        if (need > DEPTH)
            need = DEPTH;
        for (int i = DEPTH - 1; i > 0; i--) begin
            win_x[i] = win_x[i-1];
            win_y[i] = win_y[i-1];
            win_z[i] = win_z[i-1];
        end
        win_x[0] = it.x;
        win_y[0] = it.y;
        win_z[0] = it.z;
        win_fill = (win_fill + 1 > need) ? need : win_fill + 1;
        if (win_fill < need)
            return v;
        agree = 1'b1;
        for (int i = 0; i < need; i++) begin
            if (axis_sq(win_x[i], win_x[0]) + axis_sq(win_y[i], win_y[0])
                    + axis_sq(win_z[i], win_z[0]) > cfg_thresh)
                agree = 1'b0;
        end
        if (!agree)
            return v;
        v.status = STAT_OK;
        v.x = win_x[0];
        v.y = win_y[0];
        v.z = win_z[0];
        v.rx = it.rx;
        v.ry = it.ry;
        v.rz = it.rz;
        v.rw = it.rw;
        return v;
    endfunction

    // offer one item and wait for its handshake; valid stays up for the next one
    task automatic send_pose(input logic [REQ_W-1:0] req, input logic [TICK_W-1:0] ticks,
                             input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z,
                             input logic signed [ROT_W-1:0] rx, input logic signed [ROT_W-1:0] ry,
                             input logic signed [ROT_W-1:0] rz, input logic signed [ROT_W-1:0] rw);
        pose_req_t it;
        it = '{req: req, ticks: ticks, x: x, y: y, z: z, rx: rx, ry: ry, rz: rz, rw: rw};
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= it.req;
        i_s_tdata <= {it.rw, it.rz, it.ry, it.rx, it.z, it.y, it.x, it.ticks};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pending_verdicts.push_back(predict_settle(it));
        n_items++;
    endtask

    // stop offering and wait until every expected result is back
    task automatic wait_results_drained;
        i_s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_REQUIRED: cfg_required = data[NREQ_W-1:0];
            CFG_THRESH:   cfg_thresh = data;
            CFG_TIMEOUT:  cfg_timeout = data[TMO_W-1:0];
            default: ;
        endcase
    endtask

    // new register setting, only ever with the block idle
    task automatic apply_settings(input logic [NREQ_W-1:0] req, input logic [THR_W-1:0] thr,
                                  input logic [TMO_W-1:0] tmo);
        wait_results_drained();
        write_reg(CFG_REQUIRED, THR_W'(req));
        write_reg(CFG_THRESH, thr);
        write_reg(CFG_TIMEOUT, THR_W'(tmo));
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // defaults after reset: settle, plain and spare polls, far sample, timeout
    task automatic test_default_settle;
        send_pose(REQ_START, 16'hFFFF, POS_MIN, POS_MAX, POS_MIN, ROT_MIN, ROT_MAX, ROT_MIN, ROT_MAX);
        repeat (4)
            send_pose(REQ_SAMPLE, 16'd0, POS_MAX, POS_MAX, POS_MAX,
                      ROT_MAX, ROT_MIN, ROT_MAX, ROT_MIN);
        send_pose(REQ_SAMPLE, 16'd3, POS_MAX - 5, POS_MAX, POS_MAX - 6,
                  ROT_MIN, ROT_MAX, ROT_MIN, ROT_MAX);
        send_pose(REQ_POLL, 16'd1, POS_MIN, POS_MIN, POS_MIN, ROT_MIN, ROT_MIN, ROT_MIN, ROT_MIN);
        send_pose(REQ_SPARE, 16'd1, POS_MAX, POS_MAX, POS_MAX, ROT_MAX, ROT_MAX, ROT_MAX, ROT_MAX);
        send_pose(REQ_SAMPLE, 16'd0, POS_MIN, POS_MIN, POS_MIN, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_pose(REQ_POLL, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0);
        // timed-out sample is dropped
        send_pose(REQ_SAMPLE, 16'd0, POS_MAX, POS_MAX, POS_MAX, ROT_MAX, ROT_MAX, ROT_MAX, ROT_MAX);
        send_pose(REQ_START, 16'd0, '0, '0, '0, '0, '0, '0, '0);
    endtask

    // register extremes: zero and oversized counts, zero and full tolerance and timeout
    task automatic test_config_extremes;
        apply_settings('0, '0, '0);
        send_pose(REQ_START, 16'd9, '0, '0, '0, '0, '0, '0, '0);
        send_pose(REQ_SAMPLE, 16'd0, POS_MIN, POS_MAX, POS_MIN, ROT_MAX, ROT_MIN, ROT_MAX, ROT_MIN);
        send_pose(REQ_SAMPLE, 16'd0, POS_MAX, POS_MIN, POS_MAX, ROT_MIN, ROT_MAX, ROT_MIN, ROT_MAX);
        send_pose(REQ_POLL, 16'd1, '0, '0, '0, '0, '0, '0, '0);

        apply_settings('1, '1, '1);
        send_pose(REQ_START, 16'd0, '0, '0, '0, '0, '0, '0, '0);
        for (int k = 0; k < DEPTH; k++)
            send_pose(REQ_SAMPLE, 16'hFFFF, k[0] ? POS_MAX : POS_MIN, k[0] ? POS_MIN : POS_MAX,
                      k[0] ? POS_MAX : POS_MIN, ROT_W'(k), ROT_MIN, ROT_MAX, ROT_W'(-k));

        // count lowered without a restart: only the newest two are compared
        apply_settings(5'd2, '0, '1);
        send_pose(REQ_SAMPLE, 16'd0, POS_MAX, POS_MIN, POS_MAX, ROT_MAX, ROT_MAX, ROT_MIN, ROT_MIN);
    endtask

    // receiver held off for a long stretch while items keep coming
    task automatic test_output_backpressure;
        hold_pending = 1'b1;
        send_pose(REQ_START, 16'd0, '0, '0, '0, '0, '0, '0, '0);
        repeat (12)
            send_pose(REQ_SAMPLE, $urandom_range(0, 20), 24'sd1000, 24'sd2000,
                      24'sd3000, $urandom, $urandom, $urandom, $urandom);
    endtask

    // elapsed counter runs up into saturation with the largest timeout
    task automatic test_elapsed_saturation;
        apply_settings(5'd1, '1, '1);
        send_pose(REQ_START, 16'd0, '0, '0, '0, '0, '0, '0, '0);
        while (elapsed_sum != '1)
            send_pose(REQ_POLL, 16'hFFFF, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        send_pose(REQ_POLL, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0);
        send_pose(REQ_SAMPLE, 16'hFFFF, POS_MAX, POS_MIN, 24'sd7, ROT_MIN, ROT_MAX, 16'sd1, -16'sd1);
        // one below the saturated count fails without a restart
        apply_settings(5'd1, '1, 32'hFFFF_FFFE);
        send_pose(REQ_SAMPLE, 16'd0, POS_MIN, POS_MAX, 24'sd7, ROT_MAX, ROT_MIN, 16'sd1, -16'sd1);
        send_pose(REQ_START, 16'd0, '0, '0, '0, '0, '0, '0, '0);
    endtask

    // one well-formed run: optional restart, samples around a centre, some polls
    task automatic settle_sequence;
        int cx;
        int cy;
        int cz;
        int jit;
        int len;
        int pick;
        logic [TICK_W-1:0] ticks;
        if ($urandom_range(0, 99) < 80)
            send_pose(REQ_START, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        cx = $urandom_range(0, 16_000_000) - 8_000_000;
        cy = $urandom_range(0, 16_000_000) - 8_000_000;
        cz = $urandom_range(0, 16_000_000) - 8_000_000;
        case ($urandom_range(0, 3))
            0: jit = 0;
            1: jit = 2;
            2: jit = 6;
            default: jit = 20;
        endcase
        len = $urandom_range(1, 20);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            ticks = ($urandom_range(0, 99) < 4) ? $urandom : $urandom_range(0, 150);
            if (pick < 2)
                send_pose(REQ_SPARE, ticks, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            else if (pick < 12)
                send_pose(REQ_POLL, ticks, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            else if (pick < 18)
                send_pose(REQ_SAMPLE, ticks, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            else
                send_pose(REQ_SAMPLE, ticks,
                          POS_W'(cx + int'($urandom_range(0, 2 * jit)) - jit),
                          POS_W'(cy + int'($urandom_range(0, 2 * jit)) - jit),
                          POS_W'(cz + int'($urandom_range(0, 2 * jit)) - jit),
                          $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // random runs and noise under a series of random settings
    task automatic run_random_phase(input int n_target);
        int done_at;
        int next_cfg;
        logic [NREQ_W-1:0] req;
        logic [THR_W-1:0]  thr;
        logic [TMO_W-1:0]  tmo;
        done_at = n_items + n_target;
        next_cfg = n_items;
        while (n_items < done_at) begin
            if (n_items >= next_cfg) begin
                req = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
                case ($urandom_range(0, 9))
                    0: thr = {$urandom, $urandom};
                    1: thr = '0;
                    default: thr = $urandom_range(0, 3000);
                endcase
                case ($urandom_range(0, 9))
                    0: tmo = $urandom;
                    1: tmo = $urandom_range(0, 300);
                    default: tmo = $urandom_range(1000, 60000);
                endcase
                apply_settings(req, thr, tmo);
                next_cfg = n_items + $urandom_range(40, 90);
            end
            if ($urandom_range(0, 99) < 80)
                settle_sequence();
            else
                repeat ($urandom_range(1, 4))
                    send_pose($urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // result side ready, with random idling and the long hold-off
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                repeat (HOLD_CYCLES) begin
                    i_m_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic void check_field(input string fname, input longint want, input longint got);
        if (want != got) begin
            if (n_errors < MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
            n_errors++;
        end
    endfunction

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        verdict_t want;
        verdict_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = o_m_tuser;
            got.x  = o_m_tdata[POS_W-1:0];
            got.y  = o_m_tdata[2*POS_W-1:POS_W];
            got.z  = o_m_tdata[3*POS_W-1:2*POS_W];
            got.rx = o_m_tdata[3*POS_W+ROT_W-1:3*POS_W];
            got.ry = o_m_tdata[3*POS_W+2*ROT_W-1:3*POS_W+ROT_W];
            got.rz = o_m_tdata[3*POS_W+3*ROT_W-1:3*POS_W+2*ROT_W];
            got.rw = o_m_tdata[3*POS_W+4*ROT_W-1:3*POS_W+3*ROT_W];
            n_verdicts++;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with none expected, status %0d", $time, got.status);
                n_errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (want.status == STAT_OK)
                    n_settled++;
                if (want.status == STAT_FAIL)
                    n_timed_out++;
                check_field("status", want.status, got.status);
                check_field("out_x", want.x, got.x);
                check_field("out_y", want.y, got.y);
                check_field("out_z", want.z, got.z);
                check_field("out_rot_x", want.rx, got.rx);
                check_field("out_rot_y", want.ry, got.ry);
                check_field("out_rot_z", want.rz, got.rz);
                check_field("out_rot_w", want.rw, got.rw);
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        cfg_required = RST_REQUIRED;
        cfg_thresh = RST_THRESH;
        cfg_timeout = RST_TIMEOUT;
        win_fill = 0;
        elapsed_sum = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_settle();
        test_config_extremes();
        run_random_phase(270);

        send_idle_pct = 71;
        recv_idle_pct = 6;
        run_random_phase(270);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        run_random_phase(270);
        test_elapsed_saturation();
        wait_results_drained();

        $display("covered %0d items and %0d results over %0d register settings",
                 n_items, n_verdicts, n_settings);
        $display("%0d settled, %0d timed out, %0d field errors",
                 n_settled, n_timed_out, n_errors);
        if (n_errors == 0)
            $display("steady_pose_settle_detector: match");
        else
            $display("steady_pose_settle_detector: mismatch");
        $finish;
    end

endmodule
